FILE: src/tsgf_pkg.sv
// Package for the touch sample gesture filter.
// Holds the sequencer states, register indexes, swipe codes and fixed constants.
// No dependencies.
package tsgf_pkg;

	// Fixed field widths
	localparam int RAW_W   = 12;
	localparam int TIME_W  = 32;
	localparam int DEB_W   = 16;
	localparam int SWT_W   = 9;
	localparam int DIR_W   = 3;
	localparam int CFG_W   = 16;
	localparam int CIDX_W  = 3;

	// Pressure ceiling, swipe window and hold radius
	localparam logic [RAW_W-1:0]  PRESS_CEIL  = 12'd4000;
	localparam logic [TIME_W-1:0] SWIPE_WIN   = 32'd500;
	localparam int                HOLD_RADIUS = 10;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_UPDATE,
		ST_DETECT
	} tsgf_state_t;

	// Configuration register indexes
	typedef enum logic [CIDX_W-1:0] {
		REG_CAL_X_MIN   = 3'd0,
		REG_CAL_X_MAX   = 3'd1,
		REG_CAL_Y_MIN   = 3'd2,
		REG_CAL_Y_MAX   = 3'd3,
		REG_DEBOUNCE    = 3'd4,
		REG_PRESS_THR   = 3'd5,
		REG_SWIPE_THR   = 3'd6,
		REG_LONG_PRESS  = 3'd7
	} tsgf_reg_t;

	// Swipe direction codes
	typedef enum logic [DIR_W-1:0] {
		DIR_NONE  = 3'd0,
		DIR_LEFT  = 3'd1,
		DIR_RIGHT = 3'd2,
		DIR_UP    = 3'd3,
		DIR_DOWN  = 3'd4
	} tsgf_dir_t;

endpackage

FILE: src/touch_sample_gesture_filter.sv
// Top level of the touch sample gesture filter: debounce, calibration, swipe and long press.
// Depends on tsgf_pkg for states, register indexes, codes and constants.
//
// Usage: one input item carries a touch flag, raw x, y, pressure and a millisecond
// time stamp; every input item gives exactly one result item with the pressed flag,
// the calibrated screen position, a swipe direction and a long-press flag.
// Both channels use valid/ready. Configuration is a write-only register port
// (cfg_wr_en, cfg_index, cfg_data) and should only be written while the block is idle.
//
// Sequencing: an item is taken only in the idle state. An accepted
// sample then passes through the set-up state, DW division steps where
// DW = 12 + clog2(max(SCREEN_W, SCREEN_H) + 1) (21 at the default screen size),
// the state update and the detection state. Rejected or untouched samples
// skip the division. The pace is set by the restoring dividers, which produce
// one quotient bit per cycle for each axis in parallel.
// Reset clears the filter state and loads the default calibration values.
// When the receiver stalls, the result waits in the output register; the next item
// may already be taken and worked on, and stops only at its detection cycle.
module touch_sample_gesture_filter #(
	parameter int SCREEN_W = 320,
	parameter int SCREEN_H = 240
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration write port
	input  logic                                 cfg_wr_en,
	input  logic [tsgf_pkg::CIDX_W-1:0]          cfg_index,
	input  logic [tsgf_pkg::CFG_W-1:0]           cfg_data,
	// Sample input channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 touched,
	input  logic [tsgf_pkg::RAW_W-1:0]           raw_x,
	input  logic [tsgf_pkg::RAW_W-1:0]           raw_y,
	input  logic [tsgf_pkg::RAW_W-1:0]           raw_z,
	input  logic [tsgf_pkg::TIME_W-1:0]          now_ms,
	// Result channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 pressed,
	output logic [$clog2(SCREEN_W)-1:0]          pos_x,
	output logic [$clog2(SCREEN_H)-1:0]          pos_y,
	output logic [tsgf_pkg::DIR_W-1:0]           swipe_dir,
	output logic                                 long_press
);
	import tsgf_pkg::*;

	localparam int XW   = $clog2(SCREEN_W);
	localparam int YW   = $clog2(SCREEN_H);
	localparam int SMAX = (SCREEN_W > SCREEN_H) ? SCREEN_W : SCREEN_H;
	localparam int DW   = RAW_W + $clog2(SMAX + 1);
	localparam int CW   = $clog2(DW);
	localparam int AW0  = (XW > YW) ? XW : YW;
	localparam int AW   = (AW0 > SWT_W) ? AW0 : SWT_W;

	// Configuration registers
	logic [RAW_W-1:0]  cal_x_min_q, cal_x_max_q, cal_y_min_q, cal_y_max_q;
	logic [DEB_W-1:0]  debounce_q, long_press_ms_q;
	logic [RAW_W-1:0]  press_thr_q;
	logic [SWT_W-1:0]  swipe_thr_q;

	// Captured sample
	logic              touched_q;
	logic [RAW_W-1:0]  raw_x_q, raw_y_q, raw_z_q;
	logic [TIME_W-1:0] now_q;

	// Filter state
	logic [XW-1:0]     cur_x_q, start_x_q;
	logic [YW-1:0]     cur_y_q, start_y_q;
	logic              cur_pressed_q, start_valid_q, held_q;
	logic [TIME_W-1:0] cur_time_q, start_time_q, last_accept_q, last_swipe_q;

	// Sequencer and dividers
	tsgf_state_t       state_q, state_d;
	logic              acc_q;
	logic [CW-1:0]     cnt_q;
	logic              zx_q, zy_q;
	logic [DW-1:0]     dvx_q, dvy_q;
	logic [RAW_W-1:0]  remx_q, remy_q, denx_q, deny_q;

	// Output register
	logic              out_valid_q;
	logic              pressed_q, long_press_q;
	logic [XW-1:0]     pos_x_q;
	logic [YW-1:0]     pos_y_q;
	logic [DIR_W-1:0]  swipe_dir_q;

	// Control decoded from the state
	logic              take_item, out_free, ld_out;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_x_min_q     <= 12'd300;
			cal_x_max_q     <= 12'd3800;
			cal_y_min_q     <= 12'd300;
			cal_y_max_q     <= 12'd3800;
			debounce_q      <= 16'd50;
			press_thr_q     <= 12'd200;
			swipe_thr_q     <= 9'd50;
			long_press_ms_q <= 16'd1000;
		end else if (cfg_wr_en) begin
			unique case (tsgf_reg_t'(cfg_index))
				REG_CAL_X_MIN:  cal_x_min_q     <= cfg_data[RAW_W-1:0];
				REG_CAL_X_MAX:  cal_x_max_q     <= cfg_data[RAW_W-1:0];
				REG_CAL_Y_MIN:  cal_y_min_q     <= cfg_data[RAW_W-1:0];
				REG_CAL_Y_MAX:  cal_y_max_q     <= cfg_data[RAW_W-1:0];
				REG_DEBOUNCE:   debounce_q      <= cfg_data[DEB_W-1:0];
				REG_PRESS_THR:  press_thr_q     <= cfg_data[RAW_W-1:0];
				REG_SWIPE_THR:  swipe_thr_q     <= cfg_data[SWT_W-1:0];
				REG_LONG_PRESS: long_press_ms_q <= cfg_data[DEB_W-1:0];
				default: ;
			endcase
		end
	end

	// Next-state logic of the sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_SETUP;
			ST_SETUP:  state_d = acc_c ? ST_DIV : ST_UPDATE;
			ST_DIV:    if (cnt_q == '0) state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_DETECT;
			ST_DETECT: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer
	always_comb begin
		out_free  = !out_valid_q || out_ready;
		take_item = (state_q == ST_IDLE) && in_valid;
		ld_out    = (state_q == ST_DETECT) && out_free;
		in_ready  = (state_q == ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the sample when it is taken
	always_ff @(posedge clk) begin
		if (take_item) begin
			touched_q <= touched;
			raw_x_q   <= raw_x;
			raw_y_q   <= raw_y;
			raw_z_q   <= raw_z;
			now_q     <= now_ms;
		end
	end

	// Acceptance test: touched, outside the debounce window, pressure in range
	logic              acc_c;
	logic [TIME_W-1:0] since_accept;
	always_comb begin
		since_accept = now_q - last_accept_q;
		acc_c = touched_q && (since_accept >= TIME_W'(debounce_q)) &&
			(raw_z_q > press_thr_q) && (raw_z_q < PRESS_CEIL);
	end

	// Set-up of both axes: magnitudes, sign agreement and the scaled dividend
	logic              x_ge, xs_ge, y_ge, ys_ge;
	logic [RAW_W-1:0]  numx_mag, spnx_mag, numy_mag, spny_mag;
	logic [DW-1:0]     prodx, prody;
	always_comb begin
		x_ge     = raw_x_q >= cal_x_min_q;
		xs_ge    = cal_x_max_q >= cal_x_min_q;
		y_ge     = raw_y_q >= cal_y_min_q;
		ys_ge    = cal_y_max_q >= cal_y_min_q;
		numx_mag = x_ge  ? raw_x_q - cal_x_min_q : cal_x_min_q - raw_x_q;
		spnx_mag = xs_ge ? cal_x_max_q - cal_x_min_q : cal_x_min_q - cal_x_max_q;
		numy_mag = y_ge  ? raw_y_q - cal_y_min_q : cal_y_min_q - raw_y_q;
		spny_mag = ys_ge ? cal_y_max_q - cal_y_min_q : cal_y_min_q - cal_y_max_q;
		prodx    = DW'(numx_mag) * DW'(SCREEN_W);
		prody    = DW'(numy_mag) * DW'(SCREEN_H);
	end

	// One restoring division step per axis
	logic [RAW_W:0]    trialx, trialy;
	logic              qbx, qby;
	always_comb begin
		trialx = {remx_q, dvx_q[DW-1]};
		trialy = {remy_q, dvy_q[DW-1]};
		qbx    = trialx >= {1'b0, denx_q};
		qby    = trialy >= {1'b0, deny_q};
	end

	// Dividers: the dividend shifts out at the top while quotient bits enter below
	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP) begin
			acc_q  <= acc_c;
			cnt_q  <= CW'(DW - 1);
			zx_q   <= (spnx_mag == '0) || (x_ge != xs_ge);
			zy_q   <= (spny_mag == '0) || (y_ge != ys_ge);
			dvx_q  <= prodx;
			dvy_q  <= prody;
			denx_q <= spnx_mag;
			deny_q <= spny_mag;
			remx_q <= '0;
			remy_q <= '0;
		end else if (state_q == ST_DIV) begin
			cnt_q  <= cnt_q - 1'b1;
			dvx_q  <= {dvx_q[DW-2:0], qbx};
			dvy_q  <= {dvy_q[DW-2:0], qby};
			remx_q <= qbx ? RAW_W'(trialx - {1'b0, denx_q}) : trialx[RAW_W-1:0];
			remy_q <= qby ? RAW_W'(trialy - {1'b0, deny_q}) : trialy[RAW_W-1:0];
		end
	end

	// Clamp the quotients to the screen
	logic [XW-1:0]     map_x;
	logic [YW-1:0]     map_y;
	always_comb begin
		priority if (zx_q)                       map_x = '0;
		else if (dvx_q > DW'(SCREEN_W - 1))      map_x = XW'(SCREEN_W - 1);
		else                                     map_x = XW'(dvx_q);
		priority if (zy_q)                       map_y = '0;
		else if (dvy_q > DW'(SCREEN_H - 1))      map_y = YW'(SCREEN_H - 1);
		else                                     map_y = YW'(dvy_q);
	end

	// Gesture detection on the updated state
	logic              dx_pos, dy_pos;
	logic [AW-1:0]     adx, ady, thr_w;
	logic              swipe_go, too_slow, too_short, lp_c;
	logic [DIR_W-1:0]  dir_c;
	logic [TIME_W-1:0] since_swipe, press_span, hold_time;
	always_comb begin
		dx_pos      = cur_x_q > start_x_q;
		dy_pos      = cur_y_q > start_y_q;
		adx         = AW'(dx_pos ? cur_x_q - start_x_q : start_x_q - cur_x_q);
		ady         = AW'(dy_pos ? cur_y_q - start_y_q : start_y_q - cur_y_q);
		thr_w       = AW'(swipe_thr_q);
		since_swipe = now_q - last_swipe_q;
		press_span  = cur_time_q - start_time_q;
		hold_time   = now_q - start_time_q;
		swipe_go    = start_valid_q && !cur_pressed_q && (since_swipe >= SWIPE_WIN);
		too_slow    = press_span > SWIPE_WIN;
		too_short   = (adx < thr_w) && (ady < thr_w);
		dir_c       = DIR_NONE;
		if (swipe_go && !too_slow && !too_short) begin
			if (adx > ady) begin
				dir_c = dx_pos ? DIR_RIGHT : DIR_LEFT;
			end else begin
				dir_c = dy_pos ? DIR_DOWN : DIR_UP;
			end
		end
		lp_c = cur_pressed_q && held_q && (hold_time >= TIME_W'(long_press_ms_q)) &&
			(adx < AW'(HOLD_RADIUS)) && (ady < AW'(HOLD_RADIUS));
	end

	// Filter state: sample update, then the swipe bookkeeping when the result leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			cur_pressed_q <= 1'b0;
			cur_time_q    <= '0;
			start_x_q     <= '0;
			start_y_q     <= '0;
			start_valid_q <= 1'b0;
			start_time_q  <= '0;
			last_accept_q <= '0;
			held_q        <= 1'b0;
			last_swipe_q  <= '0;
		end else if (state_q == ST_UPDATE) begin
			if (touched_q) begin
				if (acc_q) begin
					cur_x_q       <= map_x;
					cur_y_q       <= map_y;
					cur_pressed_q <= 1'b1;
					cur_time_q    <= now_q;
					if (!held_q) begin
						start_x_q     <= map_x;
						start_y_q     <= map_y;
						start_valid_q <= 1'b1;
						start_time_q  <= now_q;
					end
					last_accept_q <= now_q;
					held_q        <= 1'b1;
				end
			end else if (held_q) begin
				cur_pressed_q <= 1'b0;
				held_q        <= 1'b0;
			end
		end else if (ld_out && swipe_go) begin
			start_valid_q <= 1'b0;
			if (dir_c != DIR_NONE) begin
				last_swipe_q <= now_q;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			pressed_q    <= cur_pressed_q;
			pos_x_q      <= cur_x_q;
			pos_y_q      <= cur_y_q;
			swipe_dir_q  <= dir_c;
			long_press_q <= lp_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign pressed    = pressed_q;
	assign pos_x      = pos_x_q;
	assign pos_y      = pos_y_q;
	assign swipe_dir  = swipe_dir_q;
	assign long_press = long_press_q;

	// A press is held exactly while the current point is pressed
	a_held_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		held_q == cur_pressed_q)
		else $error("held and pressed flags disagree");

	// A swipe is only reported once the touch has been released
	a_swipe_released: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (swipe_dir != DIR_NONE) |-> !pressed)
		else $error("swipe reported while pressed");

	// A long press is only reported while pressed and without a swipe
	a_long_press: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && long_press |-> pressed && (swipe_dir == DIR_NONE))
		else $error("long press without a press");

	// Reported position stays on the screen
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pos_x <= XW'(SCREEN_W - 1)) && (pos_y <= YW'(SCREEN_H - 1)))
		else $error("position off screen");

	// The last division step leads to the state update
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) && (cnt_q == '0) |=> (state_q == ST_UPDATE))
		else $error("division did not finish");

endmodule
